>>> rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and codes for the positional array table.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

	// command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_SEARCH = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// field widths
	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int FIDX_W  = 4;
	localparam int FILL_W  = 5;

	// input item layout
	localparam int IN_RAW_W = CMD_W + POS_W + VAL_W;
	localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
	localparam int CMD_LSB  = 0;
	localparam int POS_LSB  = CMD_LSB + CMD_W;
	localparam int VAL_LSB  = POS_LSB + POS_W;

	// result item layout
	localparam int OUT_RAW_W = STAT_W + FIDX_W + VAL_W + FILL_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	// controller to datapath commands
	typedef struct packed {
		logic take;    // latch the incoming item
		logic match;   // register the compare vector
		logic commit;  // apply the change and load the result register
	} pat_ctl_t;

endpackage

`default_nettype wire

>>> rtl/pat_ctrl.sv
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer: accepts one item, runs it through the datapath, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire logic             is_search,
	output pat_pkg::pat_ctl_t     ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIND = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		state_d    = state_q;
		ctl.take   = 1'b0;
		ctl.match  = 1'b0;
		ctl.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (is_search) begin
					ctl.match = 1'b1;
					state_d   = S_FIND;
				end else if (slot_free) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FIND: begin
				if (slot_free) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pat_dp.sv
// ----------------------------------------------------------------------------
// pat_dp
// Datapath: entry row with parallel shift, compare vector, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_dp #(
	parameter int CAPACITY = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pat_pkg::pat_ctl_t          ctl,
	input  wire logic [pat_pkg::IN_W-1:0]   in_data,
	output logic                            is_search,
	output logic [pat_pkg::OUT_W-1:0]       out_data
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW   = pat_pkg::POS_W;
	localparam int CMPW = (CW > PW) ? CW : PW;
	localparam int VW   = pat_pkg::VAL_W;

	logic [pat_pkg::CMD_W-1:0] cmd_q;
	logic [PW-1:0]             pos_q;
	logic [VW-1:0]             val_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;

	logic [VW-1:0] entries_q [CAPACITY];
	logic [VW-1:0] entries_d [CAPACITY];
	logic [VW-1:0] up_src    [CAPACITY];
	logic [VW-1:0] dn_src    [CAPACITY];

	logic [CAPACITY-1:0] match_s1;
	logic [IW-1:0]       hit_idx;
	logic                hit_any;

	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] cnt_w;
	logic [IW-1:0]   rd_idx;
	logic            ins_ok;
	logic            pos_ok;
	logic            do_ins;
	logic            do_del;
	logic            do_upd;
	logic [1:0]      status_d;
	logic [VW-1:0]   rdata_d;
	logic [IW-1:0]   found_d;

	logic [pat_pkg::STAT_W-1:0] status_q;
	logic [pat_pkg::FIDX_W-1:0] found_q;
	logic [VW-1:0]              rdata_q;
	logic [pat_pkg::FILL_W-1:0] fill_q;

	// latched item
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= in_data[pat_pkg::CMD_LSB +: pat_pkg::CMD_W];
			pos_q <= in_data[pat_pkg::POS_LSB +: PW];
			val_q <= in_data[pat_pkg::VAL_LSB +: VW];
		end
	end

	assign is_search = (cmd_q == pat_pkg::CMD_SEARCH);
	assign pos_w     = CMPW'(pos_q);
	assign cnt_w     = CMPW'(count_q);
	assign rd_idx    = pos_w[IW-1:0];
	assign ins_ok    = (count_q < CW'(CAPACITY)) && (pos_w <= cnt_w);
	assign pos_ok    = (pos_w < cnt_w);

	// neighbor taps for the shift
	for (genvar g = 0; g < CAPACITY; g++) begin : gen_tap
		if (g == 0) begin : gen_first
			assign up_src[g] = entries_q[g];
		end else begin : gen_up
			assign up_src[g] = entries_q[g-1];
		end
		if (g == CAPACITY - 1) begin : gen_last
			assign dn_src[g] = entries_q[g];
		end else begin : gen_dn
			assign dn_src[g] = entries_q[g+1];
		end
	end

	// compare vector, only valid entries may hit
	always_ff @(posedge clk) begin
		if (ctl.match) begin
			for (int i = 0; i < CAPACITY; i++)
				match_s1[i] <= (entries_q[i] == val_q) && (CW'(i) < count_q);
		end
	end

	// lowest set bit wins
	always_comb begin
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match_s1[i])
				hit_idx = IW'(i);
		end
	end
	assign hit_any = |match_s1;

	// command decode
	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_upd   = 1'b0;
		status_d = pat_pkg::ST_INVALID;
		rdata_d  = '0;
		found_d  = '0;
		count_d  = count_q;
		unique case (cmd_q)
			pat_pkg::CMD_INSERT: begin
				if (ins_ok) begin
					do_ins   = 1'b1;
					status_d = pat_pkg::ST_OK;
					count_d  = count_q + CW'(1);
				end
			end
			pat_pkg::CMD_DELETE: begin
				if (pos_ok) begin
					do_del   = 1'b1;
					status_d = pat_pkg::ST_OK;
					count_d  = count_q - CW'(1);
				end
			end
			pat_pkg::CMD_SEARCH: begin
				if (hit_any) begin
					status_d = pat_pkg::ST_OK;
					found_d  = hit_idx;
				end else begin
					status_d = pat_pkg::ST_NOT_FOUND;
				end
			end
			pat_pkg::CMD_UPDATE: begin
				if (pos_ok) begin
					do_upd   = 1'b1;
					status_d = pat_pkg::ST_OK;
				end
			end
			pat_pkg::CMD_READ: begin
				if (pos_ok) begin
					status_d = pat_pkg::ST_OK;
					rdata_d  = entries_q[rd_idx];
				end
			end
			default: begin
				status_d = pat_pkg::ST_INVALID;
			end
		endcase
	end

	// next value of every entry, all in parallel
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			entries_d[i] = entries_q[i];
			if (do_ins) begin
				if (CMPW'(i) > pos_w)
					entries_d[i] = up_src[i];
				else if (CMPW'(i) == pos_w)
					entries_d[i] = val_q;
			end else if (do_del) begin
				if (CMPW'(i) >= pos_w)
					entries_d[i] = dn_src[i];
			end else if (do_upd && (CMPW'(i) == pos_w)) begin
				entries_d[i] = val_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			for (int i = 0; i < CAPACITY; i++)
				entries_q[i] <= entries_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.commit) begin
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= status_d;
			found_q  <= pat_pkg::FIDX_W'(found_d);
			rdata_q  <= rdata_d;
			fill_q   <= pat_pkg::FILL_W'(count_d);
		end
	end

	assign out_data = pat_pkg::OUT_W'({fill_q, rdata_q, found_q, status_q});

endmodule

`default_nettype wire

>>> rtl/positional_array_table.sv
// ----------------------------------------------------------------------------
// positional_array_table
// Fixed-capacity table of signed 32-bit entries with insert, delete, search,
// update and read commands.
//
// Usage:
//   s_* channel carries one command item; m_* channel returns one result item
//   for every command. Both are valid/ready streams; an item moves on a clock
//   edge where tvalid and tready are both high.
//   Items are handled one at a time. The input is ready only when the
//   sequencer is idle; a command is latched, executed in the next cycle and
//   its result loaded into the output register. For insert, delete, update,
//   read and bad commands the execute step loads the result register once
//   the output register is free or being emptied; search first registers
//   the compare vector, then picks the lowest hit and loads the result.
//   The input stays closed from acceptance until the result is loaded, so
//   a new item is taken only once the last has reached the output register.
//   If the receiver stalls, the result stays in the output register and the
//   next command waits in its last step until the register can be loaded;
//   the next item can be accepted while a result is still waiting.
//   Reset clears the fill count and the handshake state; entry contents are
//   not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_table #(
	parameter int CAPACITY = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// tdata: command[2:0], position[7:3], operand_value[39:8]
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [pat_pkg::IN_W-1:0] s_tdata,
	// tdata: status[1:0], found_index[5:2], read_data[37:6], fill_count[42:38],
	//        zero pad
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [pat_pkg::OUT_W-1:0]     m_tdata
);

	pat_pkg::pat_ctl_t ctl;
	logic              is_search;

	pat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.is_search (is_search),
		.ctl       (ctl)
	);

	pat_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_data   (s_tdata),
		.is_search (is_search),
		.out_data  (m_tdata)
	);

`ifndef ASSERT_OFF
	// one item at a time: an accept closes the input for the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// a new result only comes from an item that was being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared with no item in flight");

	// status is always one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == pat_pkg::ST_OK ||
			m_tdata[1:0] == pat_pkg::ST_INVALID ||
			m_tdata[1:0] == pat_pkg::ST_NOT_FOUND))
		else $error("undefined status code");

	// found index is zero unless the status is ok
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != pat_pkg::ST_OK) |-> (m_tdata[5:2] == 4'd0))
		else $error("found index set on a failed command");
`endif

endmodule

`default_nettype wire
